// ----- rtl/lfr_pkg.sv -----
// Shared types and constants for the LRU frame replacement core.
package lfr_pkg;

  localparam int PAGE_IN_W = 16;
  localparam int IDX_OUT_W = 4;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 72;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};

  typedef struct packed {
    logic eval;
    logic hit_any;
    logic empty_any;
  } cell_ctl_t;

  typedef struct packed {
    logic hit;
    logic empty;
    logic sel;
  } cell_stat_t;

endpackage

// ----- rtl/lru_frame_replacement_core.sv -----
// Top level of the LRU frame replacement core: frame chain, selection and result register.
//
// Usage:
//   in_*  : one page reference per transaction, page number in in_tdata[15:0].
//   out_* : one result per reference. out_tuser is 1 on a hit, 0 on a fault.
//           out_tdata holds frame index, hit total and fault total.
//   cfg_* : cfg_we writes frames_in_use (0 acts as 1, above FRAMES as FRAMES).
//           Write only while the core is idle.
// Path: the input register holds the page, and the result register drives out_tvalid.
// Flow: a new reference is taken only when none waits in the input register;
//   the page is registered first, then the frame chain compares, picks the hit,
//   empty or least recent frame and updates ranks in one pass.
// Stall: the result register holds while out_tready is low; one further
//   reference is taken and waits in the input register until the result drains.
// Reset: every frame empty, ranks in index order, totals zero, frames_in_use 16.
//   No clearing pass; the core accepts input from the first cycle after reset.
module lru_frame_replacement_core #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lfr_pkg::IN_DATA_W-1:0]   in_tdata,   // [15:0] page
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lfr_pkg::OUT_DATA_W-1:0]  out_tdata,  // [3:0] frame_index, [35:4] hit_total,
                                                      // [67:36] fault_total, [71:68] zero
  output logic                            out_tuser,  // [0] hit
  input  logic                            cfg_we,
  input  logic [lfr_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int IW = RW;

  logic [lfr_pkg::CFG_W-1:0] frames_r;
  logic                      pend_r;
  logic [PAGE_BITS-1:0]      page_r;
  logic [PAGE_BITS-1:0]      page_c;
  logic                      out_valid_r;
  logic                      hit_r;
  logic [lfr_pkg::IDX_OUT_W-1:0] idx_r;
  logic [lfr_pkg::CNT_W-1:0] hit_cnt_r;
  logic [lfr_pkg::CNT_W-1:0] fault_cnt_r;

  logic                      in_fire;
  logic                      eval;
  logic [FRAMES-1:0]         act;
  logic [FRAMES:0]           hit_ch;
  logic [FRAMES:0]           empty_ch;
  lfr_pkg::cell_ctl_t        ctl;
  lfr_pkg::cell_stat_t       stat [FRAMES];
  logic [RW-1:0]             rank_q [FRAMES];
  logic [FRAMES-1:0]         rank_oh [FRAMES];
  logic [FRAMES-1:0]         rank_vec;
  logic [FRAMES-1:0]         sel_vec;
  logic [FRAMES-1:0]         hit_vec;
  logic [RW-1:0]             min_rank;
  logic [RW-1:0]             old_rank;
  logic [IW-1:0]             sel_idx;
  logic [lfr_pkg::IDX_OUT_W-1:0] idx4;

  generate
    if (PAGE_BITS <= lfr_pkg::PAGE_IN_W) begin : g_pg_narrow
      assign page_c = in_tdata[PAGE_BITS-1:0];
    end else begin : g_pg_wide
      assign page_c = {{(PAGE_BITS - lfr_pkg::PAGE_IN_W){1'b0}},
                       in_tdata[lfr_pkg::PAGE_IN_W-1:0]};
    end
  endgenerate

  assign in_tready = !pend_r;
  assign in_fire   = in_tvalid && in_tready;
  assign eval      = pend_r && (!out_valid_r || out_tready);

  assign ctl = '{eval: eval, hit_any: hit_ch[FRAMES], empty_any: empty_ch[FRAMES]};
  assign hit_ch[0]   = 1'b0;
  assign empty_ch[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < FRAMES; gi++) begin : g_cell
      assign act[gi] = (gi == 0) || (32'(gi) < 32'(frames_r));
      lfr_cell #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX       (gi)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .act      (act[gi]),
        .page     (page_r),
        .ctl      (ctl),
        .min_rank (min_rank),
        .old_rank (old_rank),
        .hit_ci   (hit_ch[gi]),
        .empty_ci (empty_ch[gi]),
        .hit_co   (hit_ch[gi+1]),
        .empty_co (empty_ch[gi+1]),
        .stat     (stat[gi]),
        .rank     (rank_q[gi]),
        .rank_oh  (rank_oh[gi])
      );
      assign sel_vec[gi] = stat[gi].sel;
      assign hit_vec[gi] = stat[gi].hit;
    end
  endgenerate

  always_comb begin
    rank_vec = '0;
    old_rank = '0;
    sel_idx  = '0;
    for (int i = 0; i < FRAMES; i++) begin
      rank_vec = rank_vec | rank_oh[i];
      if (sel_vec[i]) begin
        old_rank = old_rank | rank_q[i];
        sel_idx  = sel_idx | IW'(i);
      end
    end
  end

  always_comb begin
    min_rank = '0;
    for (int r = FRAMES - 1; r >= 0; r--) begin
      if (rank_vec[r]) begin
        min_rank = RW'(r);
      end
    end
  end

  generate
    if (IW >= lfr_pkg::IDX_OUT_W) begin : g_idx_wide
      assign idx4 = sel_idx[lfr_pkg::IDX_OUT_W-1:0];
    end else begin : g_idx_narrow
      assign idx4 = {{(lfr_pkg::IDX_OUT_W - IW){1'b0}}, sel_idx};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= lfr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      frames_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
    end else begin
      if (in_fire) begin
        pend_r <= 1'b1;
      end else if (eval) begin
        pend_r <= 1'b0;
      end
      if (eval) begin
        out_valid_r <= 1'b1;
        if (ctl.hit_any) begin
          if (hit_cnt_r != lfr_pkg::CNT_MAX) begin
            hit_cnt_r <= hit_cnt_r + lfr_pkg::CNT_W'(1);
          end
        end else if (fault_cnt_r != lfr_pkg::CNT_MAX) begin
          fault_cnt_r <= fault_cnt_r + lfr_pkg::CNT_W'(1);
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      page_r <= page_c;
    end
    if (eval) begin
      hit_r <= ctl.hit_any;
      idx_r <= idx4;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = hit_r;
  assign out_tdata  = {4'b0000, fault_cnt_r, hit_cnt_r, idx_r};

  a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    eval |-> $onehot(sel_vec))
    else $error("frame selection is not one-hot");

  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("more than one frame claims the hit");

  a_ranks_perm: assert property (@(posedge clk) disable iff (!rst_n)
    rank_vec[min_rank] && act[0])
    else $error("least recent rank not held by an active frame");

  a_eval_result: assert property (@(posedge clk) disable iff (!rst_n)
    eval |=> out_valid_r && !pend_r)
    else $error("evaluated reference did not reach the result register");

  a_in_pend: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> pend_r)
    else $error("accepted reference was not held");

endmodule

// ----- rtl/lfr_cell.sv -----
// One frame of the table: page, valid and recency rank with lookup and update.
module lfr_cell #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int IDX       = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  act,
  input  logic [PAGE_BITS-1:0]                  page,
  input  lfr_pkg::cell_ctl_t                    ctl,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] min_rank,
  input  logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] old_rank,
  input  logic                                  hit_ci,
  input  logic                                  empty_ci,
  output logic                                  hit_co,
  output logic                                  empty_co,
  output lfr_pkg::cell_stat_t                   stat,
  output logic [((FRAMES > 1) ? $clog2(FRAMES) : 1)-1:0] rank,
  output logic [FRAMES-1:0]                     rank_oh
);

  localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  logic [PAGE_BITS-1:0] page_r;
  logic                 valid_r;
  logic [RW-1:0]        rank_r;
  logic                 hit_here;
  logic                 empty_here;
  logic                 lru_here;
  logic                 sel;

  assign hit_here   = act && valid_r && (page_r == page) && !hit_ci;
  assign empty_here = act && !valid_r && !empty_ci;
  assign lru_here   = act && (rank_r == min_rank);
  assign hit_co     = hit_ci || (act && valid_r && (page_r == page));
  assign empty_co   = empty_ci || (act && !valid_r);

  always_comb begin
    if (ctl.hit_any) begin
      sel = hit_here;
    end else if (ctl.empty_any) begin
      sel = empty_here;
    end else begin
      sel = lru_here;
    end
  end

  assign stat    = '{hit: hit_here, empty: empty_here, sel: sel};
  assign rank    = rank_r;
  assign rank_oh = act ? (FRAMES'(1) << rank_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= RW'(IDX);
    end else if (ctl.eval) begin
      if (sel) begin
        rank_r <= RW'(FRAMES - 1);
        if (!ctl.hit_any) begin
          valid_r <= 1'b1;
        end
      end else if (rank_r > old_rank) begin
        rank_r <= rank_r - RW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.eval && sel && !ctl.hit_any) begin
      page_r <= page;
    end
  end

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the LRU frame replacement core with a built-in frame table predictor.
module tb;

  localparam int FRAMES      = 16;
  localparam int HOLD_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_ITEMS = 185;

  typedef struct packed {
    logic                          hit;
    logic [lfr_pkg::IDX_OUT_W-1:0] frame;
    logic [lfr_pkg::CNT_W-1:0]     hit_total;
    logic [lfr_pkg::CNT_W-1:0]     fault_total;
  } lookup_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [lfr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [lfr_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           out_tuser;
  logic                           cfg_we;
  logic [lfr_pkg::CFG_W-1:0]      cfg_wdata;

  logic [lfr_pkg::PAGE_IN_W-1:0] frame_pg[FRAMES];
  logic                          frame_full[FRAMES];
  int unsigned                   age_rank[FRAMES];
  logic [lfr_pkg::CNT_W-1:0]     hit_cnt;
  logic [lfr_pkg::CNT_W-1:0]     fault_cnt;
  logic [lfr_pkg::CFG_W-1:0]     frames_cfg;
  lookup_t                       pending_lookups[$];

  int  errors;
  int  stall_cycles;
  bit  idle_on;
  int  hold_req;
  int  hold_done;
  int  hold_left;

  lru_frame_replacement_core #(
    .FRAMES   (FRAMES),
    .PAGE_BITS(16)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void reset_frame_table();
    for (int i = 0; i < FRAMES; i++) begin
      frame_pg[i]   = '0;
      frame_full[i] = 1'b0;
      age_rank[i]   = i;
    end
    hit_cnt    = '0;
    fault_cnt  = '0;
    frames_cfg = lfr_pkg::CFG_RESET;
  endfunction

  function automatic int active_frames();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > FRAMES) return FRAMES;
    return int'(frames_cfg);
  endfunction

  function automatic void predict_lookup(input logic [lfr_pkg::PAGE_IN_W-1:0] page);
    int          n;
    int          sel;
    int unsigned old_rank;
    bit          found;
    bit          empty;
    lookup_t     r;
    n     = active_frames();
    sel   = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_full[i] && frame_pg[i] == page) begin
        sel   = i;
        found = 1'b1;
      end
    end
    if (found) begin
      if (hit_cnt != lfr_pkg::CNT_MAX) hit_cnt++;
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !frame_full[i]) begin
          sel   = i;
          empty = 1'b1;
        end
      end
      if (!empty) begin
        sel = 0;
        for (int i = 1; i < n; i++) begin
          if (age_rank[i] < age_rank[sel]) sel = i;
        end
      end
      frame_pg[sel]   = page;
      frame_full[sel] = 1'b1;
      if (fault_cnt != lfr_pkg::CNT_MAX) fault_cnt++;
    end
    old_rank = age_rank[sel];
    for (int i = 0; i < FRAMES; i++) begin
      if (age_rank[i] > old_rank) age_rank[i]--;
    end
    age_rank[sel] = FRAMES - 1;
    r.hit         = found;
    r.frame       = lfr_pkg::IDX_OUT_W'(sel);
    r.hit_total   = hit_cnt;
    r.fault_total = fault_cnt;
    pending_lookups.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin : check_result
    lookup_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lookups.size() == 0) begin
        report_mismatch("unexpected transaction", out_tdata[63:0], 64'h0);
      end else begin
        want = pending_lookups.pop_front();
        if (out_tuser !== want.hit)
          report_mismatch("hit", out_tuser, want.hit);
        if (out_tdata[3:0] !== want.frame)
          report_mismatch("frame_index", out_tdata[3:0], want.frame);
        if (out_tdata[35:4] !== want.hit_total)
          report_mismatch("hit_total", out_tdata[35:4], want.hit_total);
        if (out_tdata[67:36] !== want.fault_total)
          report_mismatch("fault_total", out_tdata[67:36], want.fault_total);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    out_tready = 1'b0;
    hold_done  = 0;
    hold_left  = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!rst_n) begin
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(idle_on && $urandom_range(0, 99) < 8);
      end
    end
  end

  task automatic send_page(input logic [lfr_pkg::PAGE_IN_W-1:0] page);
    @(negedge clk);
    while (idle_on && $urandom_range(0, 99) < 8) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= page;
    do @(posedge clk); while (!in_tready);
    predict_lookup(page);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_frames_in_use(input logic [lfr_pkg::CFG_W-1:0] value);
    drain_results();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    frames_cfg = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_fill_and_evict();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h5555);
    send_page(16'hAAAA);
    for (int i = 1; i <= 12; i++) send_page(lfr_pkg::PAGE_IN_W'(i));
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h8000);
    send_page(16'h5555);
    drain_results();
  endtask

  task automatic test_frame_limits();
    write_frames_in_use(5'd0);
    send_page(16'h1234);
    send_page(16'h1234);
    send_page(16'h4321);
    write_frames_in_use(5'd2);
    send_page(16'h4321);
    send_page(16'hFFFF);
    write_frames_in_use(5'd1);
    send_page(16'hFFFF);
    // frames 0 and 1 now both hold the same page; lowest index must win
    write_frames_in_use(5'd2);
    send_page(16'hFFFF);
    write_frames_in_use(5'd31);
    send_page(16'h000C);
    write_frames_in_use(5'd17);
    send_page(16'h0002);
    drain_results();
  endtask

  task automatic test_backpressure();
    hold_req++;
    for (int i = 0; i < 12; i++) begin
      send_page(lfr_pkg::PAGE_IN_W'($urandom_range(0, 65535)));
    end
    drain_results();
  endtask

  task automatic test_random_references();
    logic [lfr_pkg::CFG_W-1:0]     settings[10];
    logic [lfr_pkg::PAGE_IN_W-1:0] pool[24];
    int                            pick;
    int                            span;
    settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd8, 5'd3, 5'd17, 5'd12,
                 lfr_pkg::CFG_W'($urandom_range(0, 31)),
                 lfr_pkg::CFG_W'($urandom_range(0, 31))};
    foreach (settings[p]) begin
      write_frames_in_use(settings[p]);
      idle_on = (p != 4);
      foreach (pool[k]) pool[k] = lfr_pkg::PAGE_IN_W'($urandom_range(0, 65535));
      span = (active_frames() + 2 > 23) ? 23 : active_frames() + 2;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          send_page(pool[$urandom_range(0, span)]);
        else if (pick < 90)
          send_page(pool[$urandom_range(0, 23)]);
        else
          send_page(lfr_pkg::PAGE_IN_W'($urandom_range(0, 65535)));
      end
    end
    idle_on = 1'b1;
    drain_results();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    errors       = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    hold_req     = 0;
    reset_frame_table();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_fill_and_evict();
    test_frame_limits();
    test_backpressure();
    test_random_references();

    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_lookups.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
